@@ rtl/i2da_pkg.sv @@
`timescale 1ns / 1ps

package i2da_pkg;

    localparam int VALUE_W    = 32;
    localparam int CHAR_W     = 8;
    localparam int BCD_DIGITS = 10;
    localparam int BCD_W      = 4 * BCD_DIGITS;
    localparam int STEPS      = VALUE_W;
    localparam int STEP_CNT_W = $clog2(STEPS);
    localparam int DIG_IDX_W  = $clog2(BCD_DIGITS);

    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [3:0]        DIG_MAX  = 4'd9;

    // Sequencer states, one-hot
    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_CONV = 5'b00010,
        ST_LEAD = 5'b00100,
        ST_SIGN = 5'b01000,
        ST_EMIT = 5'b10000
    } i2da_state_t;

    // Add three to every BCD digit that is five or more, ahead of the shift
    function automatic logic [BCD_W-1:0] bcd_adjust(input logic [BCD_W-1:0] bcd);
        logic [BCD_W-1:0] res;
        logic [3:0]       dig;
        res = bcd;
        for (int i = 0; i < BCD_DIGITS; i++)
        begin
            dig = bcd[4*i +: 4];
            if (dig >= 4'd5)
            begin
                res[4*i +: 4] = dig + 4'd3;
            end
        end
        return res;
    endfunction

endpackage

@@ rtl/int_to_decimal_ascii_core.sv @@
`timescale 1ns / 1ps

// Signed 32-bit integer to decimal ASCII text.
//
// Input channel: value with in_valid / in_ready. One word is one signed
// two's-complement integer. in_ready is high only while the block is idle.
// Output channel: out_char and last with out_valid / out_ready. One word is
// one character, most significant first: '-' for a negative value, then the
// digits with no leading zeros. last marks the final digit of each number.
// Conversion: 32 steps of shift-and-add-three in the BCD unit, then the
// leading digit is located, then the characters (1 to 11) go out one at a
// time. The next number is taken as soon as its last character sits in the
// output register.
// When the receiver stalls, the output register holds its word and the
// sequencer waits. Reset returns the block to idle with no word pending.
module int_to_decimal_ascii_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic signed [i2da_pkg::VALUE_W-1:0] value,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [i2da_pkg::CHAR_W-1:0]    out_char,
    output logic                           last
);
    import i2da_pkg::*;

    i2da_state_t             state_reg, state_next;
    logic [VALUE_W-1:0]      mag_reg, mag_next;
    logic                    neg_reg, neg_next;
    logic [BCD_W-1:0]        bcd_reg, bcd_next;
    logic [STEP_CNT_W-1:0]   cnt_reg, cnt_next;
    logic [DIG_IDX_W-1:0]    idx_reg, idx_next;
    logic                    out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0]       out_char_reg, out_char_next;
    logic                    last_reg, last_next;

    logic                    in_take;
    logic                    out_free;
    logic [DIG_IDX_W-1:0]    lead_idx;
    logic [3:0]              cur_dig;
    logic [VALUE_W-1:0]      value_u;
    logic [BCD_W-1:0]        bcd_adj;

    assign value_u  = VALUE_W'(value);
    assign in_ready = (state_reg == ST_IDLE);
    assign in_take  = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    // Adjust the BCD digits ahead of the next shift
    assign bcd_adj = bcd_adjust(bcd_reg);

    // Locate the most significant nonzero digit
    always_comb
    begin
        lead_idx = '0;
        for (int i = 0; i < BCD_DIGITS; i++)
        begin
            if (bcd_reg[4*i +: 4] != 4'd0)
            begin
                lead_idx = DIG_IDX_W'(i);
            end
        end
    end

    // Select the digit under the emit pointer
    assign cur_dig = bcd_reg[{idx_reg, 2'b00} +: 4];

    // Sequencer and datapath
    always_comb
    begin
        state_next     = state_reg;
        mag_next       = mag_reg;
        neg_next       = neg_reg;
        bcd_next       = bcd_reg;
        cnt_next       = cnt_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        out_char_next  = out_char_reg;
        last_next      = last_reg;

        // drop the output word once taken
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    neg_next   = value_u[VALUE_W-1];
                    mag_next   = value_u[VALUE_W-1] ? (VALUE_W'(0) - value_u) : value_u;
                    bcd_next   = '0;
                    cnt_next   = '0;
                    state_next = ST_CONV;
                end
            end
            ST_CONV:
            begin
                // one double-dabble step: adjust, then shift in the next bit
                bcd_next = {bcd_adj[BCD_W-2:0], mag_reg[VALUE_W-1]};
                mag_next = {mag_reg[VALUE_W-2:0], 1'b0};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == STEP_CNT_W'(STEPS - 1))
                begin
                    state_next = ST_LEAD;
                end
            end
            ST_LEAD:
            begin
                idx_next   = lead_idx;
                state_next = neg_reg ? ST_SIGN : ST_EMIT;
            end
            ST_SIGN:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_char_next  = CH_MINUS;
                    last_next      = 1'b0;
                    state_next     = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_char_next  = CH_ZERO + CHAR_W'(cur_dig);
                    last_next      = (idx_reg == '0);
                    if (idx_reg == '0)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg - 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold payload
    always_ff @(posedge clk)
    begin
        mag_reg      <= mag_next;
        neg_reg      <= neg_next;
        bcd_reg      <= bcd_next;
        cnt_reg      <= cnt_next;
        idx_reg      <= idx_next;
        out_char_reg <= out_char_next;
        last_reg     <= last_next;
    end

    assign out_valid = out_valid_reg;
    assign out_char  = out_char_reg;
    assign last      = last_reg;

endmodule

@@ rtl/i2da_checker.sv @@
`timescale 1ns / 1ps

module i2da_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_ready,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic [i2da_pkg::CHAR_W-1:0] out_char,
    input logic                        last
);
    import i2da_pkg::*;

    // A stalled output word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_char) && $stable(last))
        else $error("output word changed while stalled");

    // Only a minus sign or a decimal digit leaves the block
    a_char_set: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_char == CH_MINUS) ||
                      (out_char >= CH_ZERO && out_char <= CH_ZERO + CHAR_W'(DIG_MAX)))
        else $error("output character out of range");

    // A minus sign never ends a number
    a_sign_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_char == CH_MINUS) |-> !last)
        else $error("minus sign flagged as last");

    // The block is busy right after taking a word
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("ready right after accepting a word");

endmodule

bind int_to_decimal_ascii_core i2da_checker u_i2da_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_char  (out_char),
    .last      (last)
);

@@ bench/int_to_decimal_ascii_core_tb.sv @@
`timescale 1ns / 1ps

module int_to_decimal_ascii_core_tb;

    import i2da_pkg::*;

    localparam int          N_RANDOM    = 460;
    localparam int          IDLE_PCT    = 7;
    localparam int          CALM_FROM   = 6000;
    localparam int          CALM_TO     = 12000;
    localparam int          CYCLE_LIMIT = 400000;
    localparam int          TAIL_CYCLES = 60;
    localparam logic [31:0] RADIX       = 32'd10;

    typedef struct {
        logic signed [VALUE_W-1:0] num;
        bit                        settle;  // wait for all text before sending
    } number_t;

    typedef struct {
        logic [CHAR_W-1:0] ch;
        logic              fin;
    } char_t;

    logic                      clk;
    logic                      rst_n;
    logic                      in_valid = 1'b0;
    logic                      in_ready;
    logic signed [VALUE_W-1:0] value = '0;
    logic                      out_valid;
    logic                      out_ready = 1'b0;
    logic [CHAR_W-1:0]         out_char;
    logic                      last;

    number_t numbers_to_send[$];
    char_t   chars_due[$];
    int      mismatches = 0;
    int      cycle_count = 0;
    bit      word_taken = 1'b0;
    bit      calm = 1'b0;

    int_to_decimal_ascii_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .value     (value),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_char  (out_char),
        .last      (last)
    );

    // Free-running clock
    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    // Append the decimal text of one number to the characters due
    task automatic spell_decimal(input logic signed [VALUE_W-1:0] num);
        logic [VALUE_W-1:0] mag;
        logic [CHAR_W-1:0]  digs[BCD_DIGITS];
        int                 nd;
        char_t              c;
        nd  = 0;
        mag = num[VALUE_W-1] ? (32'd0 - num) : num;
        do
        begin
            digs[nd] = CH_ZERO + CHAR_W'(mag % RADIX);
            nd++;
            mag = mag / RADIX;
        end
        while (mag != 0 && nd < BCD_DIGITS);
        if (num[VALUE_W-1])
        begin
            c.ch  = CH_MINUS;
            c.fin = 1'b0;
            chars_due.push_back(c);
        end
        for (int k = nd - 1; k >= 0; k--)
        begin
            c.ch  = digs[k];
            c.fin = (k == 0);
            chars_due.push_back(c);
        end
    endtask

    task automatic queue_number(input logic signed [VALUE_W-1:0] num, input bit settle);
        number_t n;
        n.num    = num;
        n.settle = settle;
        numbers_to_send.push_back(n);
    endtask

    // Random number with a random count of digits and sign, or at times a full random word
    function automatic logic signed [VALUE_W-1:0] pick_number();
        logic [VALUE_W-1:0] top;
        logic [VALUE_W-1:0] mag;
        int                 nd;
        nd = $urandom_range(1, 10);
        if (nd == 10 || $urandom_range(0, 3) == 0)
        begin
            return $urandom;
        end
        top = 1;
        for (int i = 0; i < nd; i++)
        begin
            top = top * RADIX;
        end
        mag = $urandom_range(0, top - 1);
        return $urandom_range(0, 1) ? -$signed(mag) : $signed(mag);
    endfunction

    // Cycle count, timeout, and the calm stretch with no idling
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        calm        <= (cycle_count >= CALM_FROM) && (cycle_count < CALM_TO);
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d numbers and %0d characters outstanding",
                     $realtime, numbers_to_send.size(), chars_due.size());
            $display("int_to_decimal_ascii_core_tb failed");
            $finish;
        end
    end

    // Record accepted input words and predict their text
    always @(posedge clk)
    begin
        word_taken = rst_n && in_valid && in_ready;
        if (word_taken)
        begin
            spell_decimal(value);
        end
    end

    // Drive the input channel at the falling edge
    always @(negedge clk)
    begin
        logic                      nxt_valid;
        logic signed [VALUE_W-1:0] nxt_value;
        nxt_valid = in_valid;
        nxt_value = value;
        if (!rst_n)
        begin
            nxt_valid = 1'b0;
        end
        else if (!in_valid || word_taken)
        begin
            nxt_valid = 1'b0;
            if (numbers_to_send.size() != 0
                && !(numbers_to_send[0].settle && chars_due.size() != 0)
                && (calm || $urandom_range(0, 99) >= IDLE_PCT))
            begin
                nxt_value = numbers_to_send[0].num;
                nxt_valid = 1'b1;
                void'(numbers_to_send.pop_front());
            end
        end
        in_valid <= nxt_valid;
        value    <= nxt_value;
    end

    // Stall the output channel at random
    always @(negedge clk)
    begin
        out_ready <= rst_n && (calm || $urandom_range(0, 99) >= IDLE_PCT);
    end

    // Check each output word against the oldest character due
    always @(posedge clk)
    begin
        char_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (chars_due.size() == 0)
            begin
                $display("%0t: unexpected word out_char=%h last=%b",
                         $realtime, out_char, last);
                mismatches++;
            end
            else
            begin
                want = chars_due.pop_front();
                if (out_char !== want.ch)
                begin
                    $display("%0t: out_char expected %h actual %h",
                             $realtime, want.ch, out_char);
                    mismatches++;
                end
                if (last !== want.fin)
                begin
                    $display("%0t: last expected %b actual %b",
                             $realtime, want.fin, last);
                    mismatches++;
                end
            end
        end
    end

    // Fill the queue, run reset, wait for all text, report
    initial
    begin
        rst_n = 1'b0;

        // Directed: zero, single digits, decade edges, extremes, bit patterns
        queue_number(32'sd0, 1'b0);
        queue_number(32'sd1, 1'b0);
        queue_number(-32'sd1, 1'b0);
        queue_number(32'sd9, 1'b0);
        queue_number(32'sd10, 1'b0);
        queue_number(-32'sd10, 1'b0);
        queue_number(32'sd99, 1'b0);
        queue_number(32'sd100, 1'b0);
        queue_number(-32'sd9, 1'b0);
        queue_number(32'sd2147483647, 1'b0);
        queue_number(32'h8000_0000, 1'b0);
        queue_number(-32'sd2147483647, 1'b0);
        queue_number(32'sd999999999, 1'b0);
        queue_number(32'sd1000000000, 1'b0);
        queue_number(-32'sd1000000000, 1'b0);
        queue_number(-32'sd999999999, 1'b0);
        queue_number(32'sd1234567890, 1'b0);
        queue_number(32'h5555_5555, 1'b0);
        queue_number(32'hAAAA_AAAA, 1'b0);
        queue_number(32'sd0, 1'b1);

        for (int i = 0; i < N_RANDOM; i++)
        begin
            queue_number(pick_number(), (i % 150) == 75);
        end

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        wait (numbers_to_send.size() == 0 && !in_valid);
        wait (chars_due.size() == 0);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatches == 0 && chars_due.size() == 0)
        begin
            $display("int_to_decimal_ascii_core_tb passed");
        end
        else
        begin
            $display("int_to_decimal_ascii_core_tb failed");
        end
        $finish;
    end

endmodule
